// ===== rtl/pidfl_pkg.sv =====
package pidfl_pkg;

    localparam int ID_W     = 8;
    localparam int HANDLE_W = 32;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_FIND  = 2'd2,
        FUNC_FORCE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_BAD_ID   = 2'd2,
        STAT_NOT_FREE = 2'd3
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [ID_W-1:0]      id;
        logic [HANDLE_W-1:0]  handle;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]      out_id;
        logic [HANDLE_W-1:0]  out_handle;
        status_t              status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B
    } state_t;

    typedef struct packed {
        logic init_step;
        logic accept;
        logic exec;
        logic scan_start;
        logic scan_next;
        logic swap_a;
        logic swap_b;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic scan_needed;
        logic scan_hit;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/pidfl_ctrl.sv =====
module pidfl_ctrl
    import pidfl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  sts_t  sts,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sts.init_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                priority if (sts.scan_needed) state_next = ST_SCAN;
                else if (sts.out_free)        state_next = ST_IDLE;
                else                          state_next = ST_EXEC;
            end
            ST_SCAN: begin
                if (sts.scan_hit) state_next = ST_SWAP_A;
            end
            ST_SWAP_A: begin
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EXEC: begin
                cmd.scan_start = sts.scan_needed;
                cmd.exec       = !sts.scan_needed && sts.out_free;
            end
            ST_SCAN: begin
                cmd.scan_next = !sts.scan_hit;
            end
            ST_SWAP_A: begin
                cmd.swap_a = 1'b1;
            end
            ST_SWAP_B: begin
                cmd.swap_b = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/pidfl_datapath.sv =====
module pidfl_datapath
    import pidfl_pkg::*;
#(
    parameter int NUM_IDS     = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output rsp_t  m_data,
    input  cmd_t  cmd,
    output sts_t  sts
);

    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W = $clog2(NUM_IDS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_IDS);
    localparam logic [ID_W:0]    ID_LIMIT = (ID_W + 1)'(NUM_IDS);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [HANDLE_BITS-1:0] handle_in(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_BITS+HANDLE_W-1:0] wide;
        wide = {{HANDLE_BITS{1'b0}}, h};
        return wide[HANDLE_BITS-1:0];
    endfunction

    function automatic logic [HANDLE_W-1:0] handle_out(input logic [HANDLE_BITS-1:0] h);
        logic [HANDLE_BITS+HANDLE_W-1:0] wide;
        wide = {{HANDLE_W{1'b0}}, h};
        return wide[HANDLE_W-1:0];
    endfunction

    // ring of free IDs, handle table and in-use flags
    logic [IDX_W-1:0]       ring_mem [NUM_IDS];
    logic [HANDLE_BITS-1:0] hmem     [NUM_IDS];
    logic                   use_mem  [NUM_IDS];

    logic                   ring_we, ring_re;
    logic [IDX_W-1:0]       ring_wa, ring_wd, ring_ra;
    logic [IDX_W-1:0]       ring_rdata_reg;
    logic                   h_we;
    logic [IDX_W-1:0]       h_wa;
    logic [HANDLE_BITS-1:0] h_rdata_reg;
    logic                   use_we, use_wd;
    logic [IDX_W-1:0]       use_wa;
    logic                   use_rdata_reg;

    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       init_cnt_reg;
    logic [IDX_W-1:0]       scan_ptr_reg;
    logic [IDX_W-1:0]       first_reg;

    func_t                  req_func_reg;
    logic [ID_W-1:0]        req_id_reg;
    logic [HANDLE_BITS-1:0] req_handle_reg;

    logic                   m_valid_reg, m_valid_next;
    rsp_t                   m_data_reg, rsp_next;
    logic                   load;

    logic [IDX_W-1:0]       id_idx;
    logic                   id_ok, alloc_ok, free_ok, force_ok;

    assign id_idx   = req_id_reg[IDX_W-1:0];
    assign id_ok    = ({1'b0, req_id_reg} < ID_LIMIT);
    assign alloc_ok = (count_reg != '0);
    assign free_ok  = id_ok && use_rdata_reg && (h_rdata_reg == req_handle_reg);
    assign force_ok = id_ok && !use_rdata_reg;
    assign load     = cmd.exec || cmd.swap_b;

    assign sts.init_last   = (init_cnt_reg == LAST_IDX);
    assign sts.scan_needed = (req_func_reg == FUNC_FORCE) && force_ok
                             && (ring_rdata_reg != id_idx);
    assign sts.scan_hit    = (ring_rdata_reg == id_idx);
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // memory port selection and state updates
    always_comb begin
        ring_we     = 1'b0;
        ring_wa     = tail_reg;
        ring_wd     = id_idx;
        ring_re     = 1'b0;
        ring_ra     = head_reg;
        h_we        = 1'b0;
        h_wa        = ring_rdata_reg;
        use_we      = 1'b0;
        use_wa      = id_idx;
        use_wd      = 1'b0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rsp_next    = '{out_id: req_id_reg, out_handle: '0, status: STAT_OK};

        priority if (cmd.init_step) begin
            ring_we = 1'b1;
            ring_wa = init_cnt_reg;
            ring_wd = init_cnt_reg;
            use_we  = 1'b1;
            use_wa  = init_cnt_reg;
            use_wd  = 1'b0;
        end else if (cmd.accept) begin
            ring_re = 1'b1;
            ring_ra = head_reg;
        end else if (cmd.scan_start) begin
            ring_re = 1'b1;
            ring_ra = ring_next(head_reg);
        end else if (cmd.scan_next) begin
            ring_re = 1'b1;
            ring_ra = ring_next(scan_ptr_reg);
        end else if (cmd.swap_a) begin
            ring_we = 1'b1;
            ring_wa = scan_ptr_reg;
            ring_wd = first_reg;
        end else if (cmd.swap_b) begin
            ring_we = 1'b1;
            ring_wa = head_reg;
            ring_wd = id_idx;
        end else if (cmd.exec) begin
            unique case (req_func_reg)
                FUNC_ALLOC: begin
                    if (alloc_ok) begin
                        h_we                = 1'b1;
                        use_we              = 1'b1;
                        use_wa              = ring_rdata_reg;
                        use_wd              = 1'b1;
                        head_next           = ring_next(head_reg);
                        count_next          = count_reg - 1'b1;
                        rsp_next.out_id     = ID_W'(ring_rdata_reg);
                        rsp_next.out_handle = handle_out(req_handle_reg);
                    end else begin
                        rsp_next.out_id = '0;
                        rsp_next.status = STAT_NO_FREE;
                    end
                end
                FUNC_FREE: begin
                    if (free_ok) begin
                        ring_we    = 1'b1;
                        use_we     = 1'b1;
                        use_wa     = id_idx;
                        use_wd     = 1'b0;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + 1'b1;
                    end else begin
                        rsp_next.status = STAT_BAD_ID;
                    end
                end
                FUNC_FIND: begin
                    // a freed ID reads as cleared
                    if (!id_ok) begin
                        rsp_next.status = STAT_BAD_ID;
                    end else if (use_rdata_reg) begin
                        rsp_next.out_handle = handle_out(h_rdata_reg);
                    end
                end
                FUNC_FORCE: begin
                    if (!force_ok) rsp_next.status = STAT_NOT_FREE;
                end
                default: begin
                    rsp_next.status = STAT_OK;
                end
            endcase
        end else begin
            rsp_next.status = STAT_OK;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (load)    m_valid_next = 1'b1;
        else if (m_ready)     m_valid_next = 1'b0;
        else                  m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ring_wa] <= ring_wd;
        if (ring_re) ring_rdata_reg <= ring_mem[ring_ra];
    end

    always_ff @(posedge aclk) begin
        if (h_we) hmem[h_wa] <= req_handle_reg;
        if (cmd.accept) h_rdata_reg <= hmem[s_data.id[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (use_we) use_mem[use_wa] <= use_wd;
        if (cmd.accept) use_rdata_reg <= use_mem[s_data.id[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= FULL_CNT;
            init_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cmd.init_step) init_cnt_reg <= ring_next(init_cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_func_reg   <= s_data.func;
            req_id_reg     <= s_data.id;
            req_handle_reg <= handle_in(s_data.handle);
        end
        if (cmd.scan_start) begin
            first_reg    <= ring_rdata_reg;
            scan_ptr_reg <= ring_next(head_reg);
        end else if (cmd.scan_next) begin
            scan_ptr_reg <= ring_next(scan_ptr_reg);
        end
        if (load) m_data_reg <= rsp_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("free count beyond ID range");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == tail_reg) |-> (count_reg == '0 || count_reg == FULL_CNT))
        else $error("ring pointers disagree with free count");

    a_swap_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap_a |-> (scan_ptr_reg != head_reg))
        else $error("force swap targets the head slot");

    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_free_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && req_func_reg == FUNC_FREE && free_ok)
            |-> (count_reg != FULL_CNT))
        else $error("free accepted with every ID already free");

endmodule

// ===== rtl/packet_id_free_list_allocator_core.sv =====
// Channel   Ports                        Payload   Moves
// request   s_valid / s_ready / s_data   req_t     func, id, handle
// result    m_valid / m_ready / m_data   rsp_t     out_id, out_handle, status
//
// Alloc, free, find and a force that is refused or hits the head: accept, then execute.
// A force that must search reads k ring slots past the head (1 to NUM_IDS - 1), then
// swaps into the head slot; the single read port of the ring memory sets the pace.
// After reset, fill the ring with ascending IDs and clear the in-use flags, one
// slot a cycle across all NUM_IDS slots, with s_ready low meanwhile.
// A waiting result does not block the next request; completion holds until it is taken.
module packet_id_free_list_allocator_core
    import pidfl_pkg::*;
#(
    parameter int NUM_IDS     = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output rsp_t  m_data
);

    // command and status between the sequencer and the datapath
    cmd_t cmd;
    sts_t sts;

    // sequence each request: accept, then execute or, for a searching force, the search
    // and the two-step swap into the head slot
    pidfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold the ring, handle table, pointers, in-use flags and result register
    pidfl_datapath #(
        .NUM_IDS     (NUM_IDS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
